// ===== design/pai_pkg.sv =====
// Shared types and constants of the partition agreement index block.
package pai_pkg;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_STORE,
		ST_CALC,
		ST_MUL1,
		ST_MUL2,
		ST_DIVSET,
		ST_DIV,
		ST_SQRT,
		ST_DONE
	} state_t;

	// Metric select codes
	localparam logic [1:0] MET_RAND   = 2'd0;
	localparam logic [1:0] MET_FM     = 2'd1;
	localparam logic [1:0] MET_JAC    = 2'd2;
	localparam logic [1:0] MET_UNUSED = 2'd3;

	// Fixed field widths
	localparam int LBL_IN_W  = 16;
	localparam int IDX_W     = 17;
	localparam int CNT_OUT_W = 19;

	// Q1.16 scaling and square root working widths
	localparam int Q_FRAC   = 16;
	localparam int FM_SHIFT = 34;
	localparam int QUO_W    = 35;
	localparam int SQ_W     = 36;

endpackage

// ===== design/partition_agreement_index_top.sv =====
// Top level of the partition agreement index block (pair counting, Rand/FM/Jaccard).
//
// Usage: points stream in on the s_axis channel, one item per point, with the
// two cluster labels in s_axis_tdata and the end of the data set in s_axis_tlast.
// Each point is compared against every stored point of the set, one stored point
// read from the label memory per cycle. A point beyond MAX_POINTS is dropped.
// On the last point one result item leaves on m_axis: the index in unsigned Q1.16
// and the four pair counts in m_axis_tdata, a zero-denominator flag in m_axis_tuser.
// The index comes from a bit-serial divider of 2*CW+34 steps (Rand, Jaccard);
// Fowlkes-Mallows adds two passes of one multiplier and an 18-step square root.
// The cfg channel writes metric_select (0 Rand, 1 FM, 2 Jaccard); the user writes it
// only while idle, as the block itself does not enforce this. After a result is
// handed to the output register the counts clear for the next set. The output
// register holds a result while m_axis_tready is low; the block keeps taking points
// then and stalls only if another result is ready before it leaves. arst_n clears
// the counts, the point count and metric_select; the label memory needs no clearing
// since only entries written in the current set are read.
module partition_agreement_index_top #(
	parameter int MAX_POINTS = 1024,
	parameter int LABEL_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// cfg_data: metric_select
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	// s_axis_tdata: label_first [15:0], label_second [31:16]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	// m_axis_tdata: index_value [16:0], pairs_same_both [35:17],
	// pairs_same_first_only [54:36], pairs_same_second_only [73:55],
	// pairs_split_both [92:74], zero fill [95:93]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,
	// m_axis_tuser: divide_error
	output logic        m_axis_tuser
);

	localparam int LW = (LABEL_BITS < pai_pkg::LBL_IN_W) ? LABEL_BITS : pai_pkg::LBL_IN_W;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int PW = $clog2(MAX_POINTS + 1);
	localparam longint unsigned MAX_PAIRS =
		(longint'(MAX_POINTS) * longint'(MAX_POINTS - 1)) / 2;
	localparam int CW = $clog2(MAX_PAIRS + 1);
	localparam int VW = 2 * CW;
	localparam int DW = 2 * CW + pai_pkg::FM_SHIFT;
	localparam int DCW = $clog2(DW + 1);

	pai_pkg::state_t state_q, state_d;

	logic [1:0]    metric_q;
	logic [PW-1:0] points_q;
	logic [CW-1:0] cnt_a_q, cnt_b_q, cnt_c_q, cnt_d_q;
	logic [LW-1:0] l1_q, l2_q;
	logic          last_q;
	logic [AW-1:0] scan_idx_q;
	logic          rd_vld_s1;
	logic [2*LW-1:0] rd_data_s1;
	logic [2*LW-1:0] mem [MAX_POINTS];

	logic [VW-1:0]  prod_q, a2_q;
	logic [DW-1:0]  div_num_q;
	logic [VW-1:0]  div_den_q, rem_q;
	logic [pai_pkg::QUO_W-1:0] quot_q;
	logic [DCW-1:0] div_cnt_q;
	logic [pai_pkg::SQ_W-1:0] sq_x_q, sq_res_q, sq_bit_q;
	logic [pai_pkg::IDX_W-1:0] res_idx_q;
	logic          res_err_q;

	logic          in_acc, out_free, is_full, scan_end, calc_err;
	logic [CW-1:0] sum_ab, sum_ac, sum_abc, sum_all, sum_ad;
	logic [CW-1:0] mul_x, mul_y;
	logic [VW:0]   rem_sh;
	logic          div_ge;
	logic [VW-1:0] rem_nx;
	logic [pai_pkg::QUO_W-1:0] quot_nx;
	logic [pai_pkg::SQ_W-1:0] sq_trial, sq_x_nx, sq_res_nx, sq_res_inc;
	logic          sq_ge;
	logic          e1, e2;

	assign cfg_ready = 1'b1;
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign out_free  = !m_axis_tvalid || m_axis_tready;
	assign is_full   = (points_q == PW'(MAX_POINTS));
	assign scan_end  = (PW'(scan_idx_q) == points_q - PW'(1));

	// Form the sums that the metrics need
	assign sum_ab  = cnt_a_q + cnt_b_q;
	assign sum_ac  = cnt_a_q + cnt_c_q;
	assign sum_abc = sum_ab + cnt_c_q;
	assign sum_all = sum_abc + cnt_d_q;
	assign sum_ad  = cnt_a_q + cnt_d_q;

	always_comb begin
		case (metric_q)
			pai_pkg::MET_RAND: calc_err = (sum_all == '0);
			pai_pkg::MET_FM:   calc_err = (sum_ab == '0) || (sum_ac == '0);
			pai_pkg::MET_JAC:  calc_err = (sum_abc == '0);
			default:           calc_err = 1'b0;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pai_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (is_full) begin
						state_d = s_axis_tlast ? pai_pkg::ST_CALC : pai_pkg::ST_IDLE;
					end else if (points_q == '0) begin
						state_d = pai_pkg::ST_STORE;
					end else begin
						state_d = pai_pkg::ST_SCAN;
					end
				end
			end
			pai_pkg::ST_SCAN: begin
				if (scan_end) state_d = pai_pkg::ST_STORE;
			end
			pai_pkg::ST_STORE: begin
				state_d = last_q ? pai_pkg::ST_CALC : pai_pkg::ST_IDLE;
			end
			pai_pkg::ST_CALC: begin
				if (calc_err || metric_q == pai_pkg::MET_UNUSED) begin
					state_d = pai_pkg::ST_DONE;
				end else if (metric_q == pai_pkg::MET_FM) begin
					state_d = pai_pkg::ST_MUL1;
				end else begin
					state_d = pai_pkg::ST_DIV;
				end
			end
			pai_pkg::ST_MUL1:   state_d = pai_pkg::ST_MUL2;
			pai_pkg::ST_MUL2:   state_d = pai_pkg::ST_DIVSET;
			pai_pkg::ST_DIVSET: state_d = pai_pkg::ST_DIV;
			pai_pkg::ST_DIV: begin
				if (div_cnt_q == DCW'(DW - 1)) begin
					state_d = (metric_q == pai_pkg::MET_FM) ? pai_pkg::ST_SQRT : pai_pkg::ST_DONE;
				end
			end
			pai_pkg::ST_SQRT: begin
				if (sq_bit_q[0]) state_d = pai_pkg::ST_DONE;
			end
			pai_pkg::ST_DONE: begin
				if (out_free) state_d = pai_pkg::ST_IDLE;
			end
			default: state_d = pai_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		mul_x = cnt_a_q;
		mul_y = cnt_a_q;
		unique case (state_q)
			pai_pkg::ST_IDLE: s_axis_tready = 1'b1;
			pai_pkg::ST_MUL2: begin
				mul_x = sum_ab;
				mul_y = sum_ac;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pai_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the metric register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= pai_pkg::MET_RAND;
		end else if (cfg_valid && cfg_ready) begin
			metric_q <= cfg_data;
		end
	end

	// Label memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (state_q == pai_pkg::ST_STORE) begin
			mem[points_q[AW-1:0]] <= {l2_q, l1_q};
		end
		rd_data_s1 <= mem[scan_idx_q];
	end

	assign e1 = (rd_data_s1[LW-1:0] == l1_q);
	assign e2 = (rd_data_s1[2*LW-1:LW] == l2_q);

	// Count pairs and points; clear them when the result leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			points_q  <= '0;
			cnt_a_q   <= '0;
			cnt_b_q   <= '0;
			cnt_c_q   <= '0;
			cnt_d_q   <= '0;
		end else begin
			rd_vld_s1 <= (state_q == pai_pkg::ST_SCAN);
			if (state_q == pai_pkg::ST_DONE && out_free) begin
				points_q <= '0;
				cnt_a_q  <= '0;
				cnt_b_q  <= '0;
				cnt_c_q  <= '0;
				cnt_d_q  <= '0;
			end else begin
				if (rd_vld_s1) begin
					if (e1 && e2)  cnt_a_q <= cnt_a_q + CW'(1);
					else if (e1)   cnt_b_q <= cnt_b_q + CW'(1);
					else if (e2)   cnt_c_q <= cnt_c_q + CW'(1);
					else           cnt_d_q <= cnt_d_q + CW'(1);
				end
				if (state_q == pai_pkg::ST_STORE) points_q <= points_q + PW'(1);
			end
		end
	end

	// Divider step: one quotient bit per cycle
	assign rem_sh  = {rem_q, div_num_q[DW-1]};
	assign div_ge  = (rem_sh >= {1'b0, div_den_q});
	assign rem_nx  = div_ge ? VW'(rem_sh - {1'b0, div_den_q}) : rem_sh[VW-1:0];
	assign quot_nx = {quot_q[pai_pkg::QUO_W-2:0], div_ge};

	// Square root step: one root bit per cycle
	assign sq_trial   = sq_res_q + sq_bit_q;
	assign sq_ge      = (sq_x_q >= sq_trial);
	assign sq_x_nx    = sq_ge ? (sq_x_q - sq_trial) : sq_x_q;
	assign sq_res_nx  = sq_ge ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);
	assign sq_res_inc = sq_res_nx + pai_pkg::SQ_W'(1);

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			pai_pkg::ST_IDLE: begin
				if (in_acc) begin
					l1_q   <= s_axis_tdata[LW-1:0];
					l2_q   <= s_axis_tdata[pai_pkg::LBL_IN_W+LW-1:pai_pkg::LBL_IN_W];
					last_q <= s_axis_tlast;
				end
				scan_idx_q <= '0;
			end
			pai_pkg::ST_SCAN: scan_idx_q <= scan_idx_q + AW'(1);
			pai_pkg::ST_CALC: begin
				res_idx_q <= '0;
				res_err_q <= calc_err;
				rem_q     <= '0;
				quot_q    <= '0;
				div_cnt_q <= '0;
				if (metric_q == pai_pkg::MET_RAND) begin
					div_num_q <= (DW'(sum_ad) << pai_pkg::Q_FRAC) + DW'(sum_all >> 1);
					div_den_q <= VW'(sum_all);
				end else begin
					div_num_q <= (DW'(cnt_a_q) << pai_pkg::Q_FRAC) + DW'(sum_abc >> 1);
					div_den_q <= VW'(sum_abc);
				end
			end
			pai_pkg::ST_MUL1: prod_q <= mul_x * mul_y;
			pai_pkg::ST_MUL2: begin
				a2_q   <= prod_q;
				prod_q <= mul_x * mul_y;
			end
			pai_pkg::ST_DIVSET: begin
				div_num_q <= DW'(a2_q) << pai_pkg::FM_SHIFT;
				div_den_q <= prod_q;
			end
			pai_pkg::ST_DIV: begin
				rem_q     <= rem_nx;
				quot_q    <= quot_nx;
				div_num_q <= div_num_q << 1;
				div_cnt_q <= div_cnt_q + DCW'(1);
				if (div_cnt_q == DCW'(DW - 1)) begin
					res_idx_q <= quot_nx[pai_pkg::IDX_W-1:0];
					sq_x_q    <= pai_pkg::SQ_W'(quot_nx);
					sq_res_q  <= '0;
					sq_bit_q  <= pai_pkg::SQ_W'(1) << pai_pkg::FM_SHIFT;
				end
			end
			pai_pkg::ST_SQRT: begin
				sq_x_q   <= sq_x_nx;
				sq_res_q <= sq_res_nx;
				sq_bit_q <= sq_bit_q >> 2;
				if (sq_bit_q[0]) res_idx_q <= sq_res_inc[pai_pkg::IDX_W:1];
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (state_q == pai_pkg::ST_DONE && out_free) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pai_pkg::ST_DONE && out_free) begin
			m_axis_tdata <= {3'b000,
				pai_pkg::CNT_OUT_W'(cnt_d_q), pai_pkg::CNT_OUT_W'(cnt_c_q),
				pai_pkg::CNT_OUT_W'(cnt_b_q), pai_pkg::CNT_OUT_W'(cnt_a_q), res_idx_q};
			m_axis_tuser <= res_err_q;
		end
	end

	// Divider never runs on a zero divisor
	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pai_pkg::ST_DIV |-> div_den_q != '0)
		else $error("divider running with zero divisor");

	// Point count stays within the store
	a_points: assert property (@(posedge clk) disable iff (!arst_n)
		points_q <= PW'(MAX_POINTS))
		else $error("point count beyond store depth");

	// A new result only follows the result state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == pai_pkg::ST_DONE)
		else $error("result item without result state");

	// No stored point is read while a point is being written
	a_scan_store: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pai_pkg::ST_STORE |=> !rd_vld_s1)
		else $error("compare pending after store");

endmodule
